FILE: hdl/pegs_pkg.sv
// Shared package for the particle emitter gravity step block.
// Holds the slot record type, field widths, register indices, a saturation helper and
// the spawn velocity tables. Depends on nothing.
package pegs_pkg;

    localparam int PARTICLES    = 64;
    localparam int SLOT_W       = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int Q_W          = 32;
    localparam int LIFE_W       = 11;
    localparam int GRAV_W       = 16;
    localparam int SPAWN_LIFE_W = 10;
    localparam int RAND_W       = 7;
    localparam int SLOT_FIELD_W = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int RAND_N       = 2 ** RAND_W;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_LIFE = 1'd1;

    localparam logic [GRAV_W-1:0]       GRAVITY_RST    = 16'd655;
    localparam logic [SPAWN_LIFE_W-1:0] SPAWN_LIFE_RST = 10'd60;

    // Request kinds.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // One particle slot as held in a cell of the ring.
    typedef struct packed {
        logic                     alive;
        logic signed [LIFE_W-1:0] life;
        logic signed [Q_W-1:0]    px;
        logic signed [Q_W-1:0]    py;
        logic signed [Q_W-1:0]    pz;
        logic signed [Q_W-1:0]    vx;
        logic signed [Q_W-1:0]    vy;
        logic signed [Q_W-1:0]    vz;
    } slot_t;

    typedef logic [RAND_N-1:0][Q_W-1:0] vel_tab_t;

    // Builds the table of (r + bias) / 500 in Q16.16, rounded to nearest with halves
    // away from zero. Evaluated at elaboration only.
    function automatic vel_tab_t make_vel_tab(input int bias);
        vel_tab_t tab;
        longint   num;
        for (int r = 0; r < RAND_N; r++)
        begin
            num = longint'(r + bias) * 65536;
            if (num >= 0)
                tab[r] = Q_W'((num + 250) / 500);
            else
                tab[r] = Q_W'(-((-num + 250) / 500));
        end
        return tab;
    endfunction

    localparam vel_tab_t VEL_XZ_TAB = make_vel_tab(-50);
    localparam vel_tab_t VEL_Y_TAB  = make_vel_tab(50);

    // Clamps a 33 bit sum to the signed 32 bit range.
    function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W] != v[Q_W-1])
            r = v[Q_W] ? Q_MIN : Q_MAX;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/pegs_cell.sv
// One cell of the particle ring: holds a single slot and takes its neighbour's slot
// whenever the ring shifts. Depends on pegs_pkg.
module pegs_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  pegs_pkg::slot_t d,
    output pegs_pkg::slot_t q
);

    logic            alive_reg;
    pegs_pkg::slot_t data_reg;

    // Only the live flag is cleared by reset; the data stays undefined until written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alive_reg <= 1'b0;
        else if (shift)
            alive_reg <= d.alive;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            data_reg <= d;
    end

    always_comb
    begin
        q       = data_reg;
        q.alive = alive_reg;
    end

endmodule

FILE: hdl/pegs_head.sv
// Update unit at the head of the particle ring: drops in a new particle when asked,
// then applies one tick of gravity, Euler integration and life count. Depends on pegs_pkg.
module pegs_head (
    input  pegs_pkg::slot_t                  cur,
    input  logic                             spawn_en,
    input  pegs_pkg::slot_t                  spawn_val,
    input  logic                             upd_en,
    input  logic [pegs_pkg::GRAV_W-1:0]      gravity,
    output pegs_pkg::slot_t                  nxt
);

    pegs_pkg::slot_t                      s;
    logic signed [pegs_pkg::Q_W:0]        vy_diff;
    logic                                 vy_under;
    logic signed [pegs_pkg::Q_W+1:0]      py_sum;
    logic signed [pegs_pkg::Q_W:0]        py_min_sum;
    logic signed [pegs_pkg::Q_W:0]        px_sum;
    logic signed [pegs_pkg::Q_W:0]        pz_sum;
    logic signed [pegs_pkg::LIFE_W-1:0]   life_dec;

    always_comb
    begin
        s = spawn_en ? spawn_val : cur;

        // The y position uses the new velocity. The three operand sum is valid whenever
        // vy - gravity does not underflow; otherwise the velocity clamps to the minimum.
        vy_diff    = {s.vy[pegs_pkg::Q_W-1], s.vy}
                   - {{(pegs_pkg::Q_W+1-pegs_pkg::GRAV_W){1'b0}}, gravity};
        vy_under   = vy_diff[pegs_pkg::Q_W] & ~vy_diff[pegs_pkg::Q_W-1];
        py_sum     = {{2{s.py[pegs_pkg::Q_W-1]}}, s.py}
                   + {{2{s.vy[pegs_pkg::Q_W-1]}}, s.vy}
                   - {{(pegs_pkg::Q_W+2-pegs_pkg::GRAV_W){1'b0}}, gravity};
        py_min_sum = {s.py[pegs_pkg::Q_W-1], s.py}
                   + {pegs_pkg::Q_MIN[pegs_pkg::Q_W-1], pegs_pkg::Q_MIN};
        px_sum     = {s.px[pegs_pkg::Q_W-1], s.px} + {s.vx[pegs_pkg::Q_W-1], s.vx};
        pz_sum     = {s.pz[pegs_pkg::Q_W-1], s.pz} + {s.vz[pegs_pkg::Q_W-1], s.vz};
        life_dec   = s.life - pegs_pkg::LIFE_W'(1);

        nxt = s;
        if (upd_en && s.alive)
        begin
            nxt.vy    = vy_under ? pegs_pkg::Q_MIN : vy_diff[pegs_pkg::Q_W-1:0];
            nxt.px    = pegs_pkg::sat33(px_sum);
            nxt.py    = vy_under ? pegs_pkg::sat33(py_min_sum)
                                 : pegs_pkg::sat33(py_sum[pegs_pkg::Q_W:0]);
            nxt.pz    = pegs_pkg::sat33(pz_sum);
            nxt.life  = life_dec;
            nxt.alive = ~life_dec[pegs_pkg::LIFE_W-1];
        end
    end

endmodule

FILE: hdl/particle_emitter_gravity_step.sv
// Top level of the particle emitter gravity step block.
// Instantiates the ring of pegs_cell slots and the pegs_head update unit; uses pegs_pkg.
//
// The particle table lives in a ring of PARTICLES cells, one slot per cell, and every
// request rotates the whole ring once, one slot per clock while not paused, past a
// single update unit at its head. A request is taken only while the block is idle; the
// block is ready again on the cycle after the last shift of the pass. A tick request
// spawns the new particle into the first free slot that passes the head, in slot order,
// and integrates every live slot on the way past; a read request rotates the ring
// unchanged and captures the requested slot as it passes. The result sits in an output
// register, so a new request can be taken while the previous result still waits; the
// rotation pauses before its last shift only if the output register is still full.
// Reset clears every live flag at once; slot data is undefined until first written, and
// gravity and spawn_life return to their default values. Configuration writes take effect
// at once and are expected only while the block is idle.
module particle_emitter_gravity_step (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // configuration write port
    input  logic                                     cfg_we,
    input  logic [pegs_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pegs_pkg::CFG_DATA_W-1:0]          cfg_data,
    // request channel
    input  logic                                     req_valid,
    output logic                                     req_ready,
    input  logic                                     req_type,
    input  logic [pegs_pkg::SLOT_FIELD_W-1:0]        slot_index,
    input  logic signed [pegs_pkg::Q_W-1:0]          emitter_x,
    input  logic signed [pegs_pkg::Q_W-1:0]          emitter_y,
    input  logic signed [pegs_pkg::Q_W-1:0]          emitter_z,
    input  logic [pegs_pkg::RAND_W-1:0]              rand_x,
    input  logic [pegs_pkg::RAND_W-1:0]              rand_y,
    input  logic [pegs_pkg::RAND_W-1:0]              rand_z,
    // result channel
    output logic                                     rsp_valid,
    input  logic                                     rsp_ready,
    output logic                                     spawned,
    output logic [pegs_pkg::SLOT_FIELD_W-1:0]        spawn_slot,
    output logic                                     alive,
    output logic signed [pegs_pkg::Q_W-1:0]          pos_x,
    output logic signed [pegs_pkg::Q_W-1:0]          pos_y,
    output logic signed [pegs_pkg::Q_W-1:0]          pos_z,
    output logic signed [pegs_pkg::LIFE_W-1:0]       life_left
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Width used to compare the rotation count with the requested slot, so that a slot
    // number beyond the table never matches and reads back as zero.
    localparam int CMP_W = (pegs_pkg::SLOT_W > pegs_pkg::SLOT_FIELD_W) ?
                           pegs_pkg::SLOT_W + 1 : pegs_pkg::SLOT_FIELD_W + 1;
    localparam logic [pegs_pkg::SLOT_W-1:0] LAST_SLOT = pegs_pkg::SLOT_W'(pegs_pkg::PARTICLES - 1);

    // Control state.
    logic                                   state_reg;
    logic [pegs_pkg::SLOT_W-1:0]            cnt_reg;
    logic                                   spawn_done_reg;
    logic                                   rsp_valid_reg;
    logic [pegs_pkg::GRAV_W-1:0]            gravity_reg;
    logic [pegs_pkg::SPAWN_LIFE_W-1:0]      spawn_life_reg;

    // Request payload held for the pass.
    logic                                   req_type_reg;
    logic [pegs_pkg::SLOT_FIELD_W-1:0]      slot_idx_reg;
    pegs_pkg::slot_t                        spawn_val_reg;
    logic [pegs_pkg::SLOT_W-1:0]            spawn_slot_reg;
    pegs_pkg::slot_t                        rd_slot_reg;

    // Output register.
    logic                                   spawned_reg;
    logic [pegs_pkg::SLOT_FIELD_W-1:0]      spawn_slot_out_reg;
    logic                                   alive_reg;
    logic signed [pegs_pkg::Q_W-1:0]        pos_x_reg;
    logic signed [pegs_pkg::Q_W-1:0]        pos_y_reg;
    logic signed [pegs_pkg::Q_W-1:0]        pos_z_reg;
    logic signed [pegs_pkg::LIFE_W-1:0]     life_left_reg;

    pegs_pkg::slot_t                        ring_q [pegs_pkg::PARTICLES];
    pegs_pkg::slot_t                        ring_d [pegs_pkg::PARTICLES];
    pegs_pkg::slot_t                        head_out;
    pegs_pkg::slot_t                        rd_final;

    logic                                   busy;
    logic                                   is_tick;
    logic                                   last;
    logic                                   out_free;
    logic                                   shift;
    logic                                   spawn_en;
    logic                                   rd_match;
    logic                                   req_accept;
    logic                                   finish;
    logic                                   final_spawned;
    logic [pegs_pkg::SLOT_W-1:0]            final_slot;

    assign busy       = (state_reg == ST_RUN);
    assign is_tick    = (req_type_reg == pegs_pkg::REQ_TICK);
    assign last       = (cnt_reg == LAST_SLOT);
    assign out_free   = !rsp_valid_reg || rsp_ready;
    // The ring holds still before its final shift until the output register is free.
    assign shift      = busy && (!last || out_free);
    assign finish     = shift && last;
    assign req_ready  = !busy;
    assign req_accept = req_valid && req_ready;

    // A new particle goes into the first free slot to reach the head during a tick.
    assign spawn_en   = busy && is_tick && !spawn_done_reg && !ring_q[0].alive;
    assign rd_match   = busy && !is_tick && (CMP_W'(cnt_reg) == CMP_W'(slot_idx_reg));

    // The slot at the head of the ring is the one whose number equals the count.
    assign rd_final      = rd_match ? ring_q[0] : rd_slot_reg;
    assign final_spawned = spawn_done_reg || spawn_en;
    assign final_slot    = spawn_en ? cnt_reg : spawn_slot_reg;

    pegs_head u_head (
        .cur       (ring_q[0]),
        .spawn_en  (spawn_en),
        .spawn_val (spawn_val_reg),
        .upd_en    (is_tick),
        .gravity   (gravity_reg),
        .nxt       (head_out)
    );

    // Slots move one cell towards the head per shift; the updated head slot re-enters
    // at the tail, so a full pass leaves every slot back in its own cell.
    always_comb
    begin
        for (int k = 0; k < pegs_pkg::PARTICLES - 1; k++)
        begin
            ring_d[k] = ring_q[k+1];
        end
        ring_d[pegs_pkg::PARTICLES-1] = head_out;
    end

    for (genvar g = 0; g < pegs_pkg::PARTICLES; g++)
    begin : g_cell
        pegs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (ring_d[g]),
            .q     (ring_q[g])
        );
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg    <= pegs_pkg::GRAVITY_RST;
            spawn_life_reg <= pegs_pkg::SPAWN_LIFE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pegs_pkg::REG_GRAVITY:
                    gravity_reg <= cfg_data[pegs_pkg::GRAV_W-1:0];
                pegs_pkg::REG_SPAWN_LIFE:
                    spawn_life_reg <= cfg_data[pegs_pkg::SPAWN_LIFE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Sequencing of one pass around the ring.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            spawn_done_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                state_reg      <= ST_RUN;
                cnt_reg        <= '0;
                spawn_done_reg <= 1'b0;
            end
            else if (shift)
            begin
                cnt_reg <= last ? '0 : cnt_reg + pegs_pkg::SLOT_W'(1);
                if (spawn_en)
                    spawn_done_reg <= 1'b1;
                if (last)
                    state_reg <= ST_IDLE;
            end

            if (finish)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Request payload, spawn record and read capture.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_type_reg        <= req_type;
            slot_idx_reg        <= slot_index;
            spawn_slot_reg      <= '0;
            rd_slot_reg         <= '0;
            spawn_val_reg.alive <= 1'b1;
            spawn_val_reg.life  <= {1'b0, spawn_life_reg};
            spawn_val_reg.px    <= emitter_x;
            spawn_val_reg.py    <= emitter_y;
            spawn_val_reg.pz    <= emitter_z;
            spawn_val_reg.vx    <= pegs_pkg::VEL_XZ_TAB[rand_x];
            spawn_val_reg.vy    <= pegs_pkg::VEL_Y_TAB[rand_y];
            spawn_val_reg.vz    <= pegs_pkg::VEL_XZ_TAB[rand_z];
        end
        else if (shift)
        begin
            if (spawn_en)
                spawn_slot_reg <= cnt_reg;
            if (rd_match)
                rd_slot_reg <= ring_q[0];
        end
    end

    // Result register, loaded on the last shift of a pass.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (is_tick)
            begin
                spawned_reg        <= final_spawned;
                spawn_slot_out_reg <= pegs_pkg::SLOT_FIELD_W'(final_slot);
                alive_reg          <= 1'b0;
                pos_x_reg          <= '0;
                pos_y_reg          <= '0;
                pos_z_reg          <= '0;
                life_left_reg      <= '0;
            end
            else
            begin
                spawned_reg        <= 1'b0;
                spawn_slot_out_reg <= '0;
                alive_reg          <= rd_final.alive;
                pos_x_reg          <= rd_final.px;
                pos_y_reg          <= rd_final.py;
                pos_z_reg          <= rd_final.pz;
                life_left_reg      <= rd_final.life;
            end
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign spawned    = spawned_reg;
    assign spawn_slot = spawn_slot_out_reg;
    assign alive      = alive_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign life_left  = life_left_reg;

endmodule
